/* src/brb_pkg.sv */
// Package with the shared types and constants of the byte ring buffer.
`timescale 1ns / 1ps
package brb_pkg;

  localparam int unsigned ACT_W      = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OFF_W      = 9;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned S_TUSER_W  = ACT_W;
  localparam int unsigned M_TDATA_W  = 16;
  localparam int unsigned M_TUSER_W  = 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned STEP_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_OLDEST = 1'b1;

  localparam logic [SIZE_W-1:0] RING_SIZE_RST = 9'd256;
  localparam logic [SIZE_W-1:0] RING_SIZE_MIN = 9'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE  = 3'd0,
    ACT_READ   = 3'd1,
    ACT_PEEK_R = 3'd2,
    ACT_PEEK_W = 3'd3,
    ACT_MOVE   = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_EXEC,
    ST_RESP
  } state_e;

endpackage

/* src/byte_ring_buffer.sv */
// Top level of the byte ring buffer: request decode, pointer control and byte store.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on s_axis: tuser carries the action, tdata the data byte and
//   the signed offset. Each request gives one result on m_axis: tdata holds the
//   byte read or peeked and the fill count, tuser the empty-read flag.
//   Ring size and the drop-oldest policy are set through the cfg write port;
//   the user must write them while no request is in flight; the block does not
//   enforce this. A ring size write also resets both pointers. Write, read,
//   clear and unused actions go from IDLE to EXEC and RESP; peek and move first
//   pass through MOD, where the offset is reduced modulo the ring size by a
//   bit-serial remainder unit, one bit per cycle over 9 bits. The store read is
//   synchronous: issued in EXEC, its byte is used in RESP. One request is in
//   flight at a time; a new one is taken only in IDLE. Reset empties the ring
//   and clears every store entry through per-entry valid bits, at once. When
//   the receiver stalls, the result is held in the output register; a further
//   request is still taken and processed and waits until that register frees.
module byte_ring_buffer #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // data_byte [7:0], offset [16:8], zero fill [23:17]
  input  logic [brb_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // action [2:0]
  input  logic [brb_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // read_byte [7:0], fill_count [15:8]
  output logic [brb_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // was_empty [0]
  output logic [brb_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [brb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [brb_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import brb_pkg::*;

  localparam int unsigned CAP = (DEPTH < 256) ? DEPTH : 256;
  localparam int unsigned PW  = $clog2(CAP);
  localparam logic [SIZE_W-1:0] CAP_SIZE = SIZE_W'(CAP);

  state_e                state_q, state_d;
  action_e               act_q;
  logic [BYTE_W-1:0]     data_q;
  logic                  neg_q;
  logic [OFF_W-1:0]      mag_q;
  logic [SIZE_W-1:0]     rem_q, rem_d;
  logic [STEP_W-1:0]     step_q;
  logic [PW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [SIZE_W-1:0]     ring_size_q;
  logic                  drop_oldest_q;
  logic                  empty_q, empty_d;
  logic                  use_rd_q, use_rd_d;

  logic [BYTE_W-1:0]     mem_q [CAP];
  logic [CAP-1:0]        valid_q;
  logic [BYTE_W-1:0]     rd_data_q;
  logic                  rd_valid_q;
  logic                  mem_we, mem_re;
  logic [PW-1:0]         mem_addr;

  logic                  m_valid_q;
  logic [M_TDATA_W-1:0]  m_data_q;
  logic                  m_empty_q;

  logic                  s_accept, out_free, load_out;
  logic [SIZE_W-1:0]     size_use;
  logic [SIZE_W:0]       rem_try;
  logic [SIZE_W-1:0]     r9, w9, inc_r, inc_w, m9, base9, tgt9, fill9;
  logic [SIZE_W:0]       sum10;
  logic [OFF_W-1:0]      in_off;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign in_off   = s_axis_tdata[BYTE_W +: OFF_W];

  always_comb begin
    if (ring_size_q < RING_SIZE_MIN) begin
      size_use = RING_SIZE_MIN;
    end else if (ring_size_q > CAP_SIZE) begin
      size_use = CAP_SIZE;
    end else begin
      size_use = ring_size_q;
    end
  end

  assign r9 = SIZE_W'(rd_ptr_q);
  assign w9 = SIZE_W'(wr_ptr_q);
  assign inc_r = ((r9 + 1'b1) >= size_use) ? '0 : r9 + 1'b1;
  assign inc_w = ((w9 + 1'b1) >= size_use) ? '0 : w9 + 1'b1;
  assign m9 = (neg_q && (rem_q != '0)) ? size_use - rem_q : rem_q;
  assign base9 = (act_q == ACT_PEEK_W) ? w9 : r9;
  assign sum10 = {1'b0, base9} + {1'b0, m9};
  assign tgt9 = (sum10 >= {1'b0, size_use}) ? SIZE_W'(sum10 - {1'b0, size_use})
                                            : SIZE_W'(sum10);
  assign fill9 = (w9 >= r9) ? w9 - r9 : size_use - r9 + w9;

  assign rem_try = {rem_q, mag_q[OFF_W-1]};
  assign rem_d = (rem_try >= {1'b0, size_use}) ? SIZE_W'(rem_try - {1'b0, size_use})
                                               : SIZE_W'(rem_try);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser inside {ACT_PEEK_R, ACT_PEEK_W, ACT_MOVE}) begin
            state_d = ST_MOD;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_MOD: begin
        if (step_q == STEP_W'(OFF_W - 1)) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    load_out      = (state_q == ST_RESP) && out_free;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = rd_ptr_q;
    rd_ptr_d      = rd_ptr_q;
    wr_ptr_d      = wr_ptr_q;
    empty_d       = 1'b0;
    use_rd_d      = 1'b0;
    if (state_q == ST_EXEC) begin
      case (act_q)
        ACT_WRITE: begin
          mem_we   = 1'b1;
          mem_addr = wr_ptr_q;
          wr_ptr_d = PW'(inc_w);
          if ((inc_w == r9) && drop_oldest_q) begin
            rd_ptr_d = PW'(inc_r);
          end
        end
        ACT_READ: begin
          mem_re   = 1'b1;
          use_rd_d = 1'b1;
          mem_addr = rd_ptr_q;
          if (rd_ptr_q != wr_ptr_q) begin
            rd_ptr_d = PW'(inc_r);
          end else begin
            empty_d = 1'b1;
          end
        end
        ACT_PEEK_R, ACT_PEEK_W: begin
          mem_re   = 1'b1;
          use_rd_d = 1'b1;
          mem_addr = PW'(tgt9);
        end
        ACT_MOVE:  rd_ptr_d = PW'(tgt9);
        ACT_CLEAR: rd_ptr_d = wr_ptr_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      rd_ptr_q      <= '0;
      wr_ptr_q      <= '0;
      ring_size_q   <= RING_SIZE_RST;
      drop_oldest_q <= 1'b1;
      valid_q       <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MOD) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (mem_we) begin
        valid_q[mem_addr] <= 1'b1;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_RING_SIZE)) begin
        ring_size_q <= cfg_wdata_i;
        rd_ptr_q    <= '0;
        wr_ptr_q    <= '0;
      end else begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_DROP_OLDEST)) begin
        drop_oldest_q <= cfg_wdata_i[0];
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      act_q  <= action_e'(s_axis_tuser);
      data_q <= s_axis_tdata[BYTE_W-1:0];
      neg_q  <= in_off[OFF_W-1];
      mag_q  <= in_off[OFF_W-1] ? (~in_off + 1'b1) : in_off;
      rem_q  <= '0;
    end else if (state_q == ST_MOD) begin
      rem_q <= rem_d;
      mag_q <= {mag_q[OFF_W-2:0], 1'b0};
    end
    if (state_q == ST_EXEC) begin
      empty_q  <= empty_d;
      use_rd_q <= use_rd_d;
    end
    if (load_out) begin
      m_data_q[BYTE_W-1:0]      <= (use_rd_q && rd_valid_q) ? rd_data_q : '0;
      m_data_q[M_TDATA_W-1:BYTE_W] <= BYTE_W'(fill9);
      m_empty_q                 <= empty_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= data_q;
    end
    if (mem_re) begin
      rd_data_q  <= mem_q[mem_addr];
      rd_valid_q <= valid_q[mem_addr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_empty_q;

endmodule

/* src/brb_checker.sv */
// Port-level checker of the byte ring buffer and its bind to the top level.
`timescale 1ns / 1ps
module brb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [brb_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input logic [brb_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
  import brb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while one is in flight");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[M_TDATA_W-1:BYTE_W] == '0)
    else $error("empty read reports nonzero fill");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/tb_byte_ring_buffer.sv */
// Self-checking testbench of the byte ring buffer: directed and random requests, checked on the fly.
`timescale 1ns / 1ps
module tb_byte_ring_buffer;
  import brb_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PRESS_AFTER = 300;
  localparam int unsigned PRESS_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [7:0] fill_count;
    logic       was_empty;
  } ring_result_t;

  class ring_checker;
    bit [7:0]     byte_mem [256];
    int unsigned  rd_ptr;
    int unsigned  wr_ptr;
    bit [8:0]     ring_size;
    bit           drop_oldest;
    ring_result_t expected_results[$];
    int unsigned  mismatches;
    int unsigned  results_seen;

    function new();
      foreach (byte_mem[i]) byte_mem[i] = 8'h00;
      rd_ptr = 0;
      wr_ptr = 0;
      ring_size = RING_SIZE_RST;
      drop_oldest = 1'b1;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function int unsigned size_in_use();
      if (ring_size < 2) return 2;
      if (ring_size > 256) return 256;
      return ring_size;
    endfunction

    function int unsigned wrap_pos(int unsigned ptr, int off, int unsigned size);
      int m;
      int unsigned r;
      m = off % int'(size);
      if (m < 0) m += int'(size);
      r = ptr + m;
      if (r >= size) r -= size;
      return r;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, bit [8:0] value);
      if (idx == CFG_RING_SIZE) begin
        ring_size = value;
        rd_ptr = 0;
        wr_ptr = 0;
      end else begin
        drop_oldest = value[0];
      end
    endfunction

    function void note_request(bit [2:0] act, bit [7:0] data, bit [8:0] raw);
      int unsigned  size;
      int unsigned  nxt;
      int           off;
      ring_result_t res;
      size = size_in_use();
      off = $signed(raw);
      res = '0;
      case (act)
        ACT_WRITE: begin
          nxt = wr_ptr + 1;
          if (nxt >= size) nxt = 0;
          byte_mem[wr_ptr] = data;
          if (nxt == rd_ptr && drop_oldest) begin
            rd_ptr = rd_ptr + 1;
            if (rd_ptr >= size) rd_ptr = 0;
          end
          wr_ptr = nxt;
        end
        ACT_READ: begin
          res.read_byte = byte_mem[rd_ptr];
          if (rd_ptr != wr_ptr) begin
            rd_ptr = rd_ptr + 1;
            if (rd_ptr >= size) rd_ptr = 0;
          end else begin
            res.was_empty = 1'b1;
          end
        end
        ACT_PEEK_R: res.read_byte = byte_mem[wrap_pos(rd_ptr, off, size)];
        ACT_PEEK_W: res.read_byte = byte_mem[wrap_pos(wr_ptr, off, size)];
        ACT_MOVE:   rd_ptr = wrap_pos(rd_ptr, off, size);
        ACT_CLEAR:  rd_ptr = wr_ptr;
        default: ;
      endcase
      res.fill_count = 8'((wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : size - rd_ptr + wr_ptr);
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [7:0] rb, logic [7:0] fill, logic empty);
      ring_result_t exp;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: none expected, got read_byte %02h fill_count %02h was_empty %b",
                   results_seen, rb, fill, empty);
        return;
      end
      exp = expected_results.pop_front();
      if (exp.read_byte !== rb || exp.fill_count !== fill || exp.was_empty !== empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp byte %02h fill %02h empty %b, got %02h %02h %b",
                   results_seen, exp.read_byte, exp.fill_count, exp.was_empty,
                   rb, fill, empty);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic [S_TUSER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ring_checker sb = new();
  int          send_calm = 0;

  byte_ring_buffer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 9))
      0:       return 255;
      1:       return -255;
      2:       return $urandom_range(0, 6) - 3;
      default: return $urandom_range(0, 510) - 255;
    endcase
  endfunction

  task automatic send_req(logic [ACT_W-1:0] act, logic [7:0] data, int off);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, off[8:0], data};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(act, data, off[8:0]);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[8:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.configure(idx, value[8:0]);
    @(negedge clk_i);
  endtask

  task automatic random_items(int count);
    int          mode;
    int          r;
    logic [2:0]  act;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (mode == 0) r = (r < 75) ? 0 : r;
      if (mode == 1) r = (r < 75) ? 50 : r;
      if (r < 40)      act = ACT_WRITE;
      else if (r < 70) act = ACT_READ;
      else if (r < 78) act = ACT_PEEK_R;
      else if (r < 86) act = ACT_PEEK_W;
      else if (r < 93) act = ACT_MOVE;
      else if (r < 97) act = ACT_CLEAR;
      else if (r < 99) act = ACT_RSVD6;
      else             act = ACT_RSVD7;
      send_req(act, 8'($urandom), pick_offset());
    end
  endtask

  task automatic run_phase(int unsigned size, int unsigned drop, int count);
    drain();
    write_reg(CFG_RING_SIZE, size);
    write_reg(CFG_DROP_OLDEST, drop);
    random_items(count);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_req(ACT_READ,   8'h00, 0);
    send_req(ACT_PEEK_R, 8'h00, 0);
    send_req(ACT_PEEK_W, 8'h00, -1);
    send_req(ACT_WRITE,  8'h00, 0);
    send_req(ACT_WRITE,  8'hFF, -256);
    send_req(ACT_WRITE,  8'hA5, 255);
    send_req(ACT_READ,   8'h00, 0);
    send_req(ACT_PEEK_R, 8'h00, 255);
    send_req(ACT_PEEK_R, 8'h00, -255);
    send_req(ACT_PEEK_W, 8'h00, -1);
    send_req(ACT_MOVE,   8'h00, 1);
    send_req(ACT_MOVE,   8'h00, -255);
    send_req(ACT_CLEAR,  8'h00, 0);
    send_req(ACT_RSVD6,  8'hFF, -1);
    send_req(ACT_RSVD7,  8'h5A, 85);
    send_req(ACT_READ,   8'h00, 0);
    drain();
    write_reg(CFG_RING_SIZE, 2);
    write_reg(CFG_DROP_OLDEST, 0);
    send_req(ACT_WRITE,  8'h11, 0);
    send_req(ACT_WRITE,  8'h22, 0);
    send_req(ACT_READ,   8'h00, 0);
    send_req(ACT_PEEK_W, 8'h00, 0);
    drain();
    write_reg(CFG_DROP_OLDEST, 1);
    send_req(ACT_WRITE,  8'h33, 0);
    send_req(ACT_WRITE,  8'h44, 0);
    send_req(ACT_READ,   8'h00, 0);
    send_req(ACT_READ,   8'h00, 0);

    run_phase(256, 1, 150);
    run_phase(2, 0, 150);
    run_phase(0, 1, 150);
    run_phase(511, 0, 150);
    run_phase(1, 1, 120);
    run_phase(3, 0, 150);
    run_phase(257, 1, 100);
    run_phase($urandom_range(2, 256), $urandom_range(0, 1), 150);
    run_phase($urandom_range(2, 16), $urandom_range(0, 1), 150);
    run_phase(255, 0, 150);
    run_phase($urandom_range(257, 511), 1, 50);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("byte_ring_buffer: match");
    end else begin
      $display("byte_ring_buffer: mismatch");
    end
    $finish;
  end

  initial begin
    int gap;
    int calm;
    bit pressed;
    gap = 0;
    calm = 0;
    pressed = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!pressed && sb.results_seen >= PRESS_AFTER) begin
        pressed = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (PRESS_CYCLES) @(negedge clk_i);
      end else if (gap > 0) begin
        gap--;
        m_axis_tready <= 1'b0;
      end else begin
        gap = pick_gap(calm);
        m_axis_tready <= (gap == 0);
        if (gap > 0) gap--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser[0]);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    do begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end while (quiet < STALL_LIMIT);
    $display("byte_ring_buffer: mismatch");
    $finish;
  end

endmodule
